// ----- design/necir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg: shared constants and key map for the NEC IR frame decoder
// Pulse timing windows, status codes and the 21-entry command-to-key lookup.
// ----------------------------------------------------------------------------
package necir_pkg;

  localparam int unsigned FRAME_BYTES_DEFAULT = 4;

  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_FRAME = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  localparam logic [15:0] LEAD_LOW_MIN  = 16'd23500;
  localparam logic [15:0] LEAD_LOW_MAX  = 16'd26265;
  localparam logic [15:0] LEAD_HIGH_MIN = 16'd11059;
  localparam logic [15:0] LEAD_HIGH_MAX = 16'd13824;
  localparam logic [15:0] BIT_LOW_MIN   = 16'd940;
  localparam logic [15:0] BIT_LOW_MAX   = 16'd2156;
  localparam logic [15:0] ZERO_HIGH_MIN = 16'd941;
  localparam logic [15:0] ZERO_HIGH_MAX = 16'd2155;
  localparam logic [15:0] ONE_HIGH_MIN  = 16'd4037;
  localparam logic [15:0] ONE_HIGH_MAX  = 16'd5252;

  localparam int unsigned KEY_ENTRIES = 21;

  localparam logic [7:0] KEY_CMD [KEY_ENTRIES] = '{
    8'h45, 8'h46, 8'h47, 8'h44, 8'h40, 8'h43, 8'h07,
    8'h15, 8'h09, 8'h16, 8'h19, 8'h0D, 8'h0C, 8'h18,
    8'h5E, 8'h08, 8'h1C, 8'h5A, 8'h42, 8'h52, 8'h4A
  };

  localparam logic [7:0] KEY_VAL [KEY_ENTRIES] = '{
    8'h00, 8'h00, 8'h1B, 8'h00, 8'h25, 8'h27, 8'h00,
    8'h28, 8'h26, 8'h30, 8'h1B, 8'h0D, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
  };

  typedef struct packed {
    logic       found;
    logic [7:0] value;
  } key_hit_t;

  function automatic logic in_window(input logic [15:0] v, input logic [15:0] lo,
                                     input logic [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic key_hit_t key_lookup(input logic [7:0] cmd);
    key_hit_t r;
    r = '0;
    for (int k = 0; k < KEY_ENTRIES; k++) begin
      if (!r.found && (KEY_CMD[k] == cmd)) begin
        r.found = 1'b1;
        r.value = KEY_VAL[k];
      end
    end
    return r;
  endfunction

endpackage

// ----- design/nec_ir_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_top: NEC infrared frame decoder
// Checks leader and bit pulse windows, assembles the frame LSB first and
// reports the bytes with a key map lookup of the command byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o  | level_i, duration_i
//  out     | output    | out_valid_o/out_ready_i| status_o, address_o,
//          |           |                        | address_inv_o, command_o,
//          |           |                        | command_inv_o, key_found_o,
//          |           |                        | key_value_o
//
// Each pulse transaction yields one result transaction: it passes through
// the input register, then the result register. One pulse per cycle is
// sustained while out_ready_i is high; the decode logic sits between the two.
// Reset clears the decode state to idle and both stages to empty.
// A stalled output holds the result register; an empty input register still
// takes one more transaction before in_ready_o drops.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top #(
  parameter int unsigned FRAME_BYTES = necir_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        level_i,
  input  logic [15:0] duration_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  address_o,
  output logic [7:0]  address_inv_o,
  output logic [7:0]  command_o,
  output logic [7:0]  command_inv_o,
  output logic        key_found_o,
  output logic [7:0]  key_value_o
);

  localparam int unsigned FrameBits = FRAME_BYTES * 8;
  localparam int unsigned IdxW      = $clog2(FrameBits);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_LEAD_HIGH = 2'd1;
  localparam logic [1:0] PH_BIT_LOW   = 2'd2;
  localparam logic [1:0] PH_BIT_HIGH  = 2'd3;

  logic                 in_valid_q;
  logic                 level_q;
  logic [15:0]          duration_q;
  logic                 advance;

  logic [1:0]           phase_q, phase_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [FrameBits-1:0] shift_q, shift_d;

  logic [FrameBits-1:0] shift_set;
  logic [31:0]          frame_word;
  logic [IdxW:0]        idx_next;
  logic                 is_zero, is_one;
  necir_pkg::key_hit_t  key_hit;

  logic [1:0]           status_d;
  logic [31:0]          bytes_d;
  logic                 found_d;
  logic [7:0]           value_d;

  logic                 out_valid_q;
  logic [1:0]           status_q;
  logic [31:0]          bytes_q;
  logic                 found_q;
  logic [7:0]           value_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      level_q    <= level_i;
      duration_q <= duration_i;
    end
  end

  // decode
  always_comb begin
    shift_set = shift_q;
    shift_set[idx_q] = is_one;
  end

  assign is_zero    = necir_pkg::in_window(duration_q, necir_pkg::ZERO_HIGH_MIN,
                                           necir_pkg::ZERO_HIGH_MAX);
  assign is_one     = necir_pkg::in_window(duration_q, necir_pkg::ONE_HIGH_MIN,
                                           necir_pkg::ONE_HIGH_MAX);
  assign idx_next   = {1'b0, idx_q} + {{IdxW{1'b0}}, 1'b1};
  assign frame_word = 32'(shift_set);
  assign key_hit    = necir_pkg::key_lookup(frame_word[23:16]);

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    shift_d  = shift_q;
    status_d = necir_pkg::STATUS_NONE;
    bytes_d  = '0;
    found_d  = 1'b0;
    value_d  = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (!level_q) begin
          if (necir_pkg::in_window(duration_q, necir_pkg::LEAD_LOW_MIN,
                                   necir_pkg::LEAD_LOW_MAX)) begin
            phase_d = PH_LEAD_HIGH;
          end else begin
            status_d = necir_pkg::STATUS_ERROR;
            idx_d    = '0;
            shift_d  = '0;
          end
        end
      end
      PH_LEAD_HIGH: begin
        if (level_q && necir_pkg::in_window(duration_q, necir_pkg::LEAD_HIGH_MIN,
                                            necir_pkg::LEAD_HIGH_MAX)) begin
          phase_d = PH_BIT_LOW;
          idx_d   = '0;
          shift_d = '0;
        end else begin
          status_d = necir_pkg::STATUS_ERROR;
          phase_d  = PH_IDLE;
          idx_d    = '0;
          shift_d  = '0;
        end
      end
      PH_BIT_LOW: begin
        if (!level_q && necir_pkg::in_window(duration_q, necir_pkg::BIT_LOW_MIN,
                                             necir_pkg::BIT_LOW_MAX)) begin
          phase_d = PH_BIT_HIGH;
        end else begin
          status_d = necir_pkg::STATUS_ERROR;
          phase_d  = PH_IDLE;
          idx_d    = '0;
          shift_d  = '0;
        end
      end
      PH_BIT_HIGH: begin
        priority if (level_q && (is_zero || is_one)) begin
          if (idx_next == (IdxW+1)'(FrameBits)) begin
            status_d = necir_pkg::STATUS_FRAME;
            bytes_d  = frame_word;
            found_d  = key_hit.found;
            value_d  = key_hit.value;
            phase_d  = PH_IDLE;
            idx_d    = '0;
            shift_d  = '0;
          end else begin
            phase_d = PH_BIT_LOW;
            idx_d   = idx_next[IdxW-1:0];
            shift_d = shift_set;
          end
        end else begin
          status_d = necir_pkg::STATUS_ERROR;
          phase_d  = PH_IDLE;
          idx_d    = '0;
          shift_d  = '0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      shift_q <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      bytes_q  <= bytes_d;
      found_q  <= found_d;
      value_q  <= value_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign address_o     = bytes_q[7:0];
  assign address_inv_o = bytes_q[15:8];
  assign command_o     = bytes_q[23:16];
  assign command_inv_o = bytes_q[31:24];
  assign key_found_o   = found_q;
  assign key_value_o   = value_q;

endmodule

// ----- dv/nec_ir_frame_decoder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_checker: scoreboard for the NEC IR frame decoder
// Watches both channels, decodes every accepted pulse with its own copy of
// the leader/bit state machine and compares each result field by field.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_checker #(
  parameter int unsigned FRAME_BYTES = necir_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        level_i,
  input  logic [15:0] duration_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  address_i,
  input  logic [7:0]  address_inv_i,
  input  logic [7:0]  command_i,
  input  logic [7:0]  command_inv_i,
  input  logic        key_found_i,
  input  logic [7:0]  key_value_i,
  output int          errors_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] address;
    logic [7:0] address_inv;
    logic [7:0] command;
    logic [7:0] command_inv;
    logic       key_found;
    logic [7:0] key_value;
  } frame_result_t;

  typedef enum logic [1:0] {
    WAIT_LEAD_LOW,
    WAIT_LEAD_HIGH,
    WAIT_BIT_LOW,
    WAIT_BIT_HIGH
  } rx_phase_e;

  rx_phase_e     rx_phase;
  logic [4:0]    bit_cnt;
  logic [31:0]   rx_bits;
  frame_result_t frame_q[$];

  function automatic void clear_rx();
    rx_phase = WAIT_LEAD_LOW;
    bit_cnt  = '0;
    rx_bits  = '0;
  endfunction

  function automatic logic in_span(input logic [15:0] v, input logic [15:0] lo,
                                   input logic [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic frame_result_t decode_pulse(input logic lvl, input logic [15:0] dur);
    frame_result_t r;
    logic          ok;
    logic          bitv;
    logic [7:0]    bytes [4];
    r    = '0;
    ok   = 1'b0;
    bitv = 1'b0;
    case (rx_phase)
      WAIT_LEAD_LOW: begin
        if (lvl) begin
          ok = 1'b1;
        end else if (in_span(dur, necir_pkg::LEAD_LOW_MIN, necir_pkg::LEAD_LOW_MAX)) begin
          rx_phase = WAIT_LEAD_HIGH;
          ok = 1'b1;
        end
      end
      WAIT_LEAD_HIGH: begin
        if (lvl && in_span(dur, necir_pkg::LEAD_HIGH_MIN, necir_pkg::LEAD_HIGH_MAX)) begin
          rx_phase = WAIT_BIT_LOW;
          bit_cnt  = '0;
          rx_bits  = '0;
          ok = 1'b1;
        end
      end
      WAIT_BIT_LOW: begin
        if (!lvl && in_span(dur, necir_pkg::BIT_LOW_MIN, necir_pkg::BIT_LOW_MAX)) begin
          rx_phase = WAIT_BIT_HIGH;
          ok = 1'b1;
        end
      end
      default: begin
        if (lvl && in_span(dur, necir_pkg::ZERO_HIGH_MIN, necir_pkg::ZERO_HIGH_MAX)) begin
          ok = 1'b1;
        end else if (lvl && in_span(dur, necir_pkg::ONE_HIGH_MIN,
                                    necir_pkg::ONE_HIGH_MAX)) begin
          bitv = 1'b1;
          ok = 1'b1;
        end
        if (ok) begin
          rx_bits[bit_cnt] = bitv;
          if (int'(bit_cnt) + 1 >= int'(FRAME_BYTES * 8)) begin
            for (int k = 0; k < 4; k++) begin
              bytes[k] = (k < int'(FRAME_BYTES)) ? rx_bits[8*k +: 8] : 8'h00;
            end
            r.status      = necir_pkg::STATUS_FRAME;
            r.address     = bytes[0];
            r.address_inv = bytes[1];
            r.command     = bytes[2];
            r.command_inv = bytes[3];
            for (int k = 0; k < int'(necir_pkg::KEY_ENTRIES); k++) begin
              if (!r.key_found && necir_pkg::KEY_CMD[k] == bytes[2]) begin
                r.key_found = 1'b1;
                r.key_value = necir_pkg::KEY_VAL[k];
              end
            end
            clear_rx();
          end else begin
            bit_cnt  = bit_cnt + 5'd1;
            rx_phase = WAIT_BIT_LOW;
          end
        end
      end
    endcase
    if (!ok) begin
      clear_rx();
      r.status = necir_pkg::STATUS_ERROR;
    end
    return r;
  endfunction

  task automatic report_fault(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_fault($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_result_t want;
    if (!rst_ni) begin
      clear_rx();
      frame_q.delete();
      errors_o = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (frame_q.size() == 0) begin
          report_fault($sformatf("result transaction with none pending, status %0d",
                                 status_i));
        end else begin
          want = frame_q.pop_front();
          check_field("status", 8'(status_i), 8'(want.status));
          check_field("address", address_i, want.address);
          check_field("address_inv", address_inv_i, want.address_inv);
          check_field("command", command_i, want.command);
          check_field("command_inv", command_inv_i, want.command_inv);
          check_field("key_found", 8'(key_found_i), 8'(want.key_found));
          check_field("key_value", key_value_i, want.key_value);
        end
      end
      if (in_valid_i && in_ready_i) begin
        frame_q.push_back(decode_pulse(level_i, duration_i));
      end
      outstanding_o <= frame_q.size();
    end
  end

endmodule

// ----- dv/nec_ir_frame_decoder_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_top_test: testbench for the NEC IR frame decoder
// Drives leader and timing window edges, then mostly well-formed frames with
// random content, some broken at a random pulse, and random noise, under
// random idle bursts on both channels; a scoreboard checks every result.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top_test;

  localparam int unsigned FRAME_BYTES = necir_pkg::FRAME_BYTES_DEFAULT;
  localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        level;
  logic [15:0] duration;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [7:0]  address;
  logic [7:0]  address_inv;
  logic [7:0]  command;
  logic [7:0]  command_inv;
  logic        key_found;
  logic [7:0]  key_value;
  int          errors;
  int          outstanding;
  int          sent = 0;
  logic        calm = 1'b0;

  nec_ir_frame_decoder_top #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .level_i      (level),
    .duration_i   (duration),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .address_o    (address),
    .address_inv_o(address_inv),
    .command_o    (command),
    .command_inv_o(command_inv),
    .key_found_o  (key_found),
    .key_value_o  (key_value)
  );

  nec_ir_frame_decoder_checker #(
    .FRAME_BYTES(FRAME_BYTES)
  ) frame_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .level_i      (level),
    .duration_i   (duration),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     (status),
    .address_i    (address),
    .address_inv_i(address_inv),
    .command_i    (command),
    .command_inv_i(command_inv),
    .key_found_i  (key_found),
    .key_value_i  (key_value),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_pulse(input logic lvl, input logic [15:0] dur);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    level    <= lvl;
    duration <= dur;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [15:0] pick_dur(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [15:0] outside(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo - 16'd1;
      1:       return hi + 16'd1;
      2:       return 16'($urandom_range(0, lo - 16'd1));
      default: return 16'($urandom_range(hi + 16'd1, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] bad_dur(input int idx);
    if (idx == 0) return outside(necir_pkg::LEAD_LOW_MIN, necir_pkg::LEAD_LOW_MAX);
    if (idx == 1) return outside(necir_pkg::LEAD_HIGH_MIN, necir_pkg::LEAD_HIGH_MAX);
    if (idx % 2 == 0) return outside(necir_pkg::BIT_LOW_MIN, necir_pkg::BIT_LOW_MAX);
    case ($urandom_range(0, 2))
      0:       return outside(necir_pkg::ZERO_HIGH_MIN, necir_pkg::ZERO_HIGH_MAX);
      1:       return outside(necir_pkg::ONE_HIGH_MIN, necir_pkg::ONE_HIGH_MAX);
      default: return 16'($urandom_range(necir_pkg::ZERO_HIGH_MAX + 16'd1,
                                         necir_pkg::ONE_HIGH_MIN - 16'd1));
    endcase
  endfunction

  task automatic send_frame(input bit broken);
    logic [31:0] word;
    logic [15:0] dur;
    logic        lvl;
    int          n_pulses;
    int          bad_at;
    word = $urandom;
    case ($urandom_range(0, 9))
      0:             word[23:16] = 8'h00;
      1, 2, 3, 4, 5: word[23:16] =
                       necir_pkg::KEY_CMD[$urandom_range(0, necir_pkg::KEY_ENTRIES - 1)];
      default:       ;
    endcase
    n_pulses = 2 + 2 * FRAME_BITS;
    bad_at   = broken ? $urandom_range(0, n_pulses - 1) : n_pulses;
    for (int idx = 0; idx < n_pulses; idx++) begin
      lvl = (idx % 2 == 1);
      if (idx == 0) begin
        dur = pick_dur(necir_pkg::LEAD_LOW_MIN, necir_pkg::LEAD_LOW_MAX);
      end else if (idx == 1) begin
        dur = pick_dur(necir_pkg::LEAD_HIGH_MIN, necir_pkg::LEAD_HIGH_MAX);
      end else if (!lvl) begin
        dur = pick_dur(necir_pkg::BIT_LOW_MIN, necir_pkg::BIT_LOW_MAX);
      end else if (word[(idx - 2) / 2]) begin
        dur = pick_dur(necir_pkg::ONE_HIGH_MIN, necir_pkg::ONE_HIGH_MAX);
      end else begin
        dur = pick_dur(necir_pkg::ZERO_HIGH_MIN, necir_pkg::ZERO_HIGH_MAX);
      end
      if (idx == bad_at) begin
        if ($urandom_range(0, 1) == 1) begin
          lvl = ~lvl;
        end else begin
          dur = bad_dur(idx);
        end
        send_pulse(lvl, dur);
        return;
      end
      send_pulse(lvl, dur);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1) == 1) begin
        send_pulse(1'($urandom), 16'($urandom));
      end else begin
        send_pulse(1'($urandom), bad_dur($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    level    = 1'b0;
    duration = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // high pulses while idle yield a result with no status; bad leader lows flag an error
    send_pulse(1'b1, 16'h0000);
    send_pulse(1'b1, 16'hFFFF);
    send_pulse(1'b0, 16'h0000);
    send_pulse(1'b0, necir_pkg::LEAD_LOW_MIN - 16'd1);
    send_pulse(1'b0, necir_pkg::LEAD_LOW_MAX + 16'd1);
    send_pulse(1'b0, 16'hFFFF);
    // leader high window edges and wrong level
    send_pulse(1'b0, necir_pkg::LEAD_LOW_MIN);
    send_pulse(1'b1, necir_pkg::LEAD_HIGH_MIN - 16'd1);
    send_pulse(1'b0, necir_pkg::LEAD_LOW_MAX);
    send_pulse(1'b1, necir_pkg::LEAD_HIGH_MAX + 16'd1);
    send_pulse(1'b0, necir_pkg::LEAD_LOW_MIN);
    send_pulse(1'b0, necir_pkg::LEAD_HIGH_MIN);
    // bit low window edges and wrong level
    send_pulse(1'b0, 16'd25000);
    send_pulse(1'b1, necir_pkg::LEAD_HIGH_MIN);
    send_pulse(1'b0, necir_pkg::BIT_LOW_MIN - 16'd1);
    send_pulse(1'b0, necir_pkg::LEAD_LOW_MAX);
    send_pulse(1'b1, necir_pkg::LEAD_HIGH_MAX);
    send_pulse(1'b1, 16'd1000);
    send_pulse(1'b0, 16'd24000);
    send_pulse(1'b1, 16'd12000);
    send_pulse(1'b0, necir_pkg::BIT_LOW_MAX + 16'd1);
    // bit high in the gap between the zero and one windows
    send_pulse(1'b0, necir_pkg::LEAD_LOW_MIN);
    send_pulse(1'b1, 16'd12000);
    send_pulse(1'b0, necir_pkg::BIT_LOW_MAX);
    send_pulse(1'b1, necir_pkg::ZERO_HIGH_MAX + 16'd1);

    while (sent < 1500) begin
      calm <= (sent >= 1300);
      case ($urandom_range(0, 9))
        0:       send_noise();
        1, 2:    send_frame(1'b1);
        default: send_frame(1'b0);
      endcase
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/necir_pkg.sv
design/nec_ir_frame_decoder_top.sv
dv/nec_ir_frame_decoder_checker.sv
dv/nec_ir_frame_decoder_top_test.sv
